// ----- design/bdc_pkg.sv -----
// shared types and constants for the button debounce, click and long-press block
// no dependencies

package bdc_pkg;

	localparam int TIME_WIDTH_DEF = 32;
	localparam int CFG_WIDTH = 16;
	localparam int ADDR_WIDTH = 3;

	localparam logic [CFG_WIDTH-1:0] DEBOUNCE_RESET = 16'd50;
	localparam logic [CFG_WIDTH-1:0] LONG_PRESS_RESET = 16'd1000;

	typedef enum logic {
		REG_DEBOUNCE   = 1'b0,
		REG_LONG_PRESS = 1'b1
	} reg_index_t;

	typedef struct packed {
		logic [CFG_WIDTH-1:0] debounce_ms;
		logic [CFG_WIDTH-1:0] long_press_ms;
	} cfg_t;

	typedef struct packed {
		logic        key_level;
		logic [31:0] now_ms;
		logic        take_click;
		logic        take_long;
	} sample_t;

	typedef struct packed {
		logic is_down;
		logic click_flag;
		logic long_flag;
	} result_t;

endpackage

// ----- design/bdc_regs.sv -----
// configuration registers on the apb-style port
// depends on bdc_pkg

module bdc_regs
	import bdc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [ADDR_WIDTH-1:0] paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready,
	output cfg_t                  cfg
);

	cfg_t       cfg_q;
	reg_index_t sel_idx;
	logic       wr_en;

	assign sel_idx = reg_index_t'(paddr[2]);
	assign wr_en   = psel && penable && pwrite;
	assign pready  = 1'b1;
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_ms   <= DEBOUNCE_RESET;
			cfg_q.long_press_ms <= LONG_PRESS_RESET;
		end else if (wr_en) begin
			case (sel_idx)
				REG_DEBOUNCE:   cfg_q.debounce_ms   <= pwdata[CFG_WIDTH-1:0];
				REG_LONG_PRESS: cfg_q.long_press_ms <= pwdata[CFG_WIDTH-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (sel_idx)
			REG_DEBOUNCE:   prdata = {{(32-CFG_WIDTH){1'b0}}, cfg_q.debounce_ms};
			REG_LONG_PRESS: prdata = {{(32-CFG_WIDTH){1'b0}}, cfg_q.long_press_ms};
			default:        prdata = '0;
		endcase
	end

endmodule

// ----- design/bdc_in_stage.sv -----
// input register for samples and the pipeline advance control
// depends on bdc_pkg

module bdc_in_stage
	import bdc_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    sample_valid,
	output logic    sample_stall,
	input  sample_t sample_d,
	input  logic    out_blocked,
	output sample_t sample_s1,
	output logic    advance
);

	logic valid_s1;

	// the held sample moves on whenever the result register can take it
	assign advance      = valid_s1 && !out_blocked;
	assign sample_stall = valid_s1 && out_blocked;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!sample_stall) begin
			valid_s1 <= sample_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!sample_stall && sample_valid) begin
			sample_s1 <= sample_d;
		end
	end

endmodule

// ----- design/bdc_press_logic.sv -----
// debounce, press tracking and pending flags, updated once per item
// depends on bdc_pkg

module bdc_press_logic
	import bdc_pkg::*;
#(
	parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	input  cfg_t    cfg,
	input  sample_t sample_s1,
	input  logic    advance,
	output result_t result_d
);

	localparam int CMP_WIDTH = (TIME_WIDTH > CFG_WIDTH) ? TIME_WIDTH : CFG_WIDTH;

	logic                  prev_level_q;
	logic [TIME_WIDTH-1:0] change_stamp_q;
	logic [TIME_WIDTH-1:0] press_stamp_q;
	logic                  held_q;
	logic                  long_done_q;
	logic                  click_wait_q;
	logic                  long_wait_q;

	logic [TIME_WIDTH-1:0] now_t;
	logic [TIME_WIDTH-1:0] stamp_n;
	logic [TIME_WIDTH-1:0] press_n;
	logic [TIME_WIDTH-1:0] stable_time;
	logic [TIME_WIDTH-1:0] hold_time;
	logic                  stable;
	logic                  long_hit;
	logic                  pressed;
	logic                  held_n;
	logic                  long_done_n;
	logic                  click_n;
	logic                  long_n;

	assign now_t       = TIME_WIDTH'(sample_s1.now_ms);
	assign stamp_n     = (sample_s1.key_level != prev_level_q) ? now_t : change_stamp_q;
	// differences wrap at the timestamp width
	assign stable_time = now_t - stamp_n;
	assign hold_time   = now_t - press_stamp_q;
	assign stable      = CMP_WIDTH'(stable_time) > CMP_WIDTH'(cfg.debounce_ms);
	assign long_hit    = CMP_WIDTH'(hold_time) > CMP_WIDTH'(cfg.long_press_ms);
	assign pressed     = !sample_s1.key_level;

	always_comb begin
		held_n      = held_q;
		long_done_n = long_done_q;
		click_n     = click_wait_q;
		long_n      = long_wait_q;
		press_n     = press_stamp_q;
		if (stable) begin
			if (pressed && !held_q) begin
				held_n      = 1'b1;
				press_n     = now_t;
				long_done_n = 1'b0;
			end else if (!pressed && held_q) begin
				held_n = 1'b0;
				if (!long_done_q) begin
					click_n = 1'b1;
				end
			end else if (pressed && held_q && !long_done_q && long_hit) begin
				long_done_n = 1'b1;
				long_n      = 1'b1;
			end
		end
	end

	assign result_d.is_down    = held_n;
	assign result_d.click_flag = click_n;
	assign result_d.long_flag  = long_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_level_q   <= 1'b1;
			change_stamp_q <= '0;
			press_stamp_q  <= '0;
			held_q         <= 1'b0;
			long_done_q    <= 1'b0;
			click_wait_q   <= 1'b0;
			long_wait_q    <= 1'b0;
		end else if (advance) begin
			prev_level_q   <= sample_s1.key_level;
			change_stamp_q <= stamp_n;
			press_stamp_q  <= press_n;
			held_q         <= held_n;
			long_done_q    <= long_done_n;
			// take bits clear after the flag has been reported
			click_wait_q   <= click_n && !sample_s1.take_click;
			long_wait_q    <= long_n && !sample_s1.take_long;
		end
	end

endmodule

// ----- design/bdc_out_stage.sv -----
// result register towards the output channel
// depends on bdc_pkg

module bdc_out_stage
	import bdc_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    advance,
	input  result_t result_d,
	input  logic    result_stall,
	output logic    result_valid,
	output logic    out_blocked,
	output result_t result_s2
);

	logic valid_s2;

	assign result_valid = valid_s2;
	assign out_blocked  = valid_s2 && result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!out_blocked) begin
			valid_s2 <= advance;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= result_d;
		end
	end

endmodule

// ----- design/button_debounce_click_longpress.sv -----
// top level of the debounced button with click and long-press detection
// depends on bdc_pkg, bdc_regs, bdc_in_stage, bdc_press_logic, bdc_out_stage
//
// channel   handshake                      payload
// sample    sample_valid / sample_stall    key_level, now_ms, take_click, take_long
// result    result_valid / result_stall    is_down, click_flag, long_flag
// config    psel, penable, pwrite, pready  paddr, pwdata, prdata
//
// one item per clock sustained while the result side does not stall; each item is held in the input
// register, and its result is offered from the result register, which it enters as the item moves on
// press state and flags update in a single pass as the item leaves the input register
// reset gives the default limits and a released button with no flags pending
// a stalled result holds the input register; sample_stall rises only when both are full

module button_debounce_click_longpress
	import bdc_pkg::*;
#(
	parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  sample_valid,
	output logic                  sample_stall,
	input  logic                  key_level,
	input  logic [31:0]           now_ms,
	input  logic                  take_click,
	input  logic                  take_long,
	output logic                  result_valid,
	input  logic                  result_stall,
	output logic                  is_down,
	output logic                  click_flag,
	output logic                  long_flag,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [ADDR_WIDTH-1:0] paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready
);

	cfg_t    cfg;
	sample_t sample_d;
	sample_t sample_s1;
	result_t result_d;
	result_t result_s2;
	logic    advance;
	logic    out_blocked;

	assign sample_d.key_level  = key_level;
	assign sample_d.now_ms     = now_ms;
	assign sample_d.take_click = take_click;
	assign sample_d.take_long  = take_long;

	assign is_down    = result_s2.is_down;
	assign click_flag = result_s2.click_flag;
	assign long_flag  = result_s2.long_flag;

	bdc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	bdc_in_stage u_in_stage (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample_d     (sample_d),
		.out_blocked  (out_blocked),
		.sample_s1    (sample_s1),
		.advance      (advance)
	);

	bdc_press_logic #(
		.TIME_WIDTH (TIME_WIDTH)
	) u_press_logic (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.sample_s1 (sample_s1),
		.advance   (advance),
		.result_d  (result_d)
	);

	bdc_out_stage u_out_stage (
		.clk          (clk),
		.arst_n       (arst_n),
		.advance      (advance),
		.result_d     (result_d),
		.result_stall (result_stall),
		.result_valid (result_valid),
		.out_blocked  (out_blocked),
		.result_s2    (result_s2)
	);

endmodule

// ----- test/tb_button_debounce_click_longpress.sv -----
// self-checking testbench for button_debounce_click_longpress: samples in, one flag set out
// depends on bdc_pkg and the design sources; the predictor tracks the press state itself

module tb_button_debounce_click_longpress;
	import bdc_pkg::*;

	// expected press state and flags, one entry per accepted sample
	class button_scoreboard;
		logic [CFG_WIDTH-1:0] debounce_ms;
		logic [CFG_WIDTH-1:0] long_press_ms;
		logic                 prev_level;
		logic [31:0]          change_stamp;
		logic [31:0]          press_stamp;
		bit                   held;
		bit                   long_done;
		bit                   click_wait;
		bit                   long_wait;
		result_t              flags_due[$];
		int                   fails;

		function new();
			debounce_ms = DEBOUNCE_RESET;
			long_press_ms = LONG_PRESS_RESET;
			prev_level = 1'b1;
			change_stamp = '0;
			press_stamp = '0;
			held = 0;
			long_done = 0;
			click_wait = 0;
			long_wait = 0;
			fails = 0;
		endfunction

		function void set_limit(reg_index_t idx, logic [CFG_WIDTH-1:0] value);
			if (idx == REG_DEBOUNCE)
				debounce_ms = value;
			else
				long_press_ms = value;
		endfunction

		function void note_sample(sample_t s);
			logic [31:0] since_change;
			logic [31:0] since_press;
			result_t     r;
			if (s.key_level != prev_level)
				change_stamp = s.now_ms;
			since_change = s.now_ms - change_stamp;
			if (since_change > {16'd0, debounce_ms}) begin
				if (s.key_level == 1'b0 && !held) begin
					held = 1;
					press_stamp = s.now_ms;
					long_done = 0;
				end else if (s.key_level == 1'b1 && held) begin
					held = 0;
					if (!long_done)
						click_wait = 1;
				end else if (s.key_level == 1'b0 && held && !long_done) begin
					since_press = s.now_ms - press_stamp;
					if (since_press > {16'd0, long_press_ms}) begin
						long_done = 1;
						long_wait = 1;
					end
				end
			end
			prev_level = s.key_level;
			r.is_down = held;
			r.click_flag = click_wait;
			r.long_flag = long_wait;
			flags_due.push_back(r);
			// takes act after the flags are reported
			if (s.take_click)
				click_wait = 0;
			if (s.take_long)
				long_wait = 0;
		endfunction

		function void check_flags(result_t got);
			result_t want;
			if (flags_due.size() == 0) begin
				$display("%0t: unexpected result, expected none, got %b%b%b", $time,
					got.is_down, got.click_flag, got.long_flag);
				fails++;
				return;
			end
			want = flags_due.pop_front();
			if (got.is_down !== want.is_down) begin
				$display("%0t: is_down expected %b actual %b", $time, want.is_down, got.is_down);
				fails++;
			end
			if (got.click_flag !== want.click_flag) begin
				$display("%0t: click_flag expected %b actual %b", $time,
					want.click_flag, got.click_flag);
				fails++;
			end
			if (got.long_flag !== want.long_flag) begin
				$display("%0t: long_flag expected %b actual %b", $time,
					want.long_flag, got.long_flag);
				fails++;
			end
		endfunction

		function int pending();
			return flags_due.size();
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  sample_valid;
	logic                  sample_stall;
	logic                  key_level;
	logic [31:0]           now_ms;
	logic                  take_click;
	logic                  take_long;
	logic                  result_valid;
	logic                  result_stall;
	logic                  is_down;
	logic                  click_flag;
	logic                  long_flag;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [ADDR_WIDTH-1:0] paddr;
	logic [31:0]           pwdata;
	logic [31:0]           prdata;
	logic                  pready;

	button_scoreboard sb;
	logic [31:0]      stamp;
	int               items_sent;
	bit               tx_gaps;
	bit               rx_gaps;
	int               squeeze_count;

	button_debounce_click_longpress dut (
		.clk(clk),
		.arst_n(arst_n),
		.sample_valid(sample_valid),
		.sample_stall(sample_stall),
		.key_level(key_level),
		.now_ms(now_ms),
		.take_click(take_click),
		.take_long(take_long),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.is_down(is_down),
		.click_flag(click_flag),
		.long_flag(long_flag),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	initial begin
		#4000000;
		$display("FAILURE");
		$finish;
	end

	// mostly no gap, sometimes a short one, now and then a long one
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return 0;
		else if (r < 95)
			return $urandom_range(1, 3);
		else
			return $urandom_range(8, 40);
	endfunction

	function automatic bit rand_take();
		return $urandom_range(0, 3) == 0;
	endfunction

	// result side: random stalls, plus a long hold-off whenever a squeeze is requested
	initial begin : result_side
		int idle_left;
		int squeeze_seen;
		idle_left = 0;
		squeeze_seen = 0;
		result_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (squeeze_seen != squeeze_count) begin
				squeeze_seen = squeeze_count;
				idle_left = 80;
			end else if (idle_left == 0 && rx_gaps) begin
				idle_left = idle_len();
			end
			if (idle_left > 0) begin
				result_stall <= 1'b1;
				idle_left--;
			end else begin
				result_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		result_t got;
		if (arst_n && result_valid && !result_stall) begin
			got.is_down = is_down;
			got.click_flag = click_flag;
			got.long_flag = long_flag;
			sb.check_flags(got);
		end
	end

	task automatic send_sample(bit lvl, logic [31:0] t, bit tc, bit tl);
		int      g;
		sample_t s;
		g = tx_gaps ? idle_len() : 0;
		if (g > 0) begin
			sample_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		sample_valid <= 1'b1;
		key_level <= lvl;
		now_ms <= t;
		take_click <= tc;
		take_long <= tl;
		do
			@(posedge clk);
		while (sample_stall);
		s.key_level = lvl;
		s.now_ms = t;
		s.take_click = tc;
		s.take_long = tl;
		sb.note_sample(s);
		items_sent++;
	endtask

	task automatic write_limit(reg_index_t idx, logic [CFG_WIDTH-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= {16'($urandom), value};
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		sb.set_limit(idx, value);
	endtask

	task automatic wait_drained();
		sample_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// bounce in, hold for a random span, bounce out, settle released
	task automatic press_episode(int deb, int lp);
		int span;
		span = deb + lp + 2;
		repeat ($urandom_range(0, 4)) begin
			stamp += $urandom_range(0, deb / 2 + 1);
			send_sample($urandom_range(0, 1), stamp, rand_take(), rand_take());
		end
		repeat ($urandom_range(1, 10)) begin
			stamp += $urandom_range(0, span / 3 + 1);
			send_sample(1'b0, stamp, rand_take(), rand_take());
		end
		repeat ($urandom_range(0, 4)) begin
			stamp += $urandom_range(0, deb / 2 + 1);
			send_sample($urandom_range(0, 1), stamp, rand_take(), rand_take());
		end
		repeat ($urandom_range(1, 4)) begin
			stamp += $urandom_range(0, deb + 2);
			send_sample(1'b1, stamp, rand_take(), rand_take());
		end
	endtask

	task automatic pick_limits(int ph, output int deb, output int lp);
		case (ph)
			0: begin deb = 0; lp = 0; end
			1: begin deb = 65535; lp = 65535; end
			2: begin deb = 7; lp = 40; end
			3: begin deb = 0; lp = 65535; end
			4: begin deb = 65535; lp = 0; end
			default: begin deb = 20; lp = 300; end
		endcase
	endtask

	initial begin
		int deb;
		int lp;
		int target;
		sb = new();
		items_sent = 0;
		squeeze_count = 0;
		tx_gaps = 1;
		rx_gaps <= 1;
		arst_n <= 1'b0;
		sample_valid <= 1'b0;
		key_level <= 1'b1;
		now_ms <= '0;
		take_click <= 1'b0;
		take_long <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// default limits: 50 ms debounce, 1000 ms long press
		send_sample(1'b1, 32'd0, 0, 0);
		send_sample(1'b1, 32'd100, 0, 0);
		send_sample(1'b0, 32'd110, 0, 0);
		send_sample(1'b1, 32'd120, 0, 0);
		send_sample(1'b0, 32'd130, 0, 0);
		// exactly at the debounce limit does not count
		send_sample(1'b0, 32'd180, 0, 0);
		send_sample(1'b0, 32'd181, 0, 0);
		send_sample(1'b0, 32'd1181, 0, 0);
		send_sample(1'b0, 32'd1182, 0, 1);
		// take with nothing pending
		send_sample(1'b0, 32'd1300, 0, 1);
		send_sample(1'b1, 32'd1400, 0, 0);
		// release after a long press gives no click
		send_sample(1'b1, 32'd1451, 0, 0);
		// debounce across the timestamp wrap
		send_sample(1'b0, 32'hFFFF_FFF0, 0, 0);
		send_sample(1'b0, 32'h0000_0030, 0, 0);
		send_sample(1'b1, 32'h0000_0040, 0, 0);
		send_sample(1'b1, 32'h0000_0080, 0, 0);
		send_sample(1'b1, 32'h0000_0090, 1, 0);
		send_sample(1'b1, 32'h0000_00A0, 1, 1);
		// timestamp going backwards reads as a huge gap
		send_sample(1'b0, 32'h0000_0100, 0, 0);
		send_sample(1'b0, 32'h0000_0050, 0, 0);
		send_sample(1'b0, 32'hFFFF_FFFF, 1, 1);
		send_sample(1'b1, 32'hFFFF_FFFF, 0, 0);
		send_sample(1'b1, 32'h0000_0000, 1, 1);

		for (int ph = 0; ph < 6; ph++) begin
			wait_drained();
			pick_limits(ph, deb, lp);
			write_limit(REG_DEBOUNCE, deb[CFG_WIDTH-1:0]);
			write_limit(REG_LONG_PRESS, lp[CFG_WIDTH-1:0]);
			tx_gaps = (ph != 3) && (ph % 3 != 1);
			rx_gaps <= (ph % 2 == 0);
			if (ph == 3)
				squeeze_count <= squeeze_count + 1;
			stamp = $urandom;
			target = items_sent + 100;
			while (items_sent < target) begin
				if ($urandom_range(0, 7) == 0) begin
					repeat ($urandom_range(1, 3)) begin
						stamp = $urandom;
						send_sample($urandom_range(0, 1), stamp, rand_take(), rand_take());
					end
				end else begin
					press_episode(deb, lp);
				end
			end
		end

		wait_drained();
		repeat (10) @(posedge clk);
		if (sb.fails == 0 && sb.pending() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
